// ----- src/mpw_pkg.sv -----
// Package for the max pooling window block: shared types, codes and defaults.
`timescale 1ns / 1ps

package mpw_pkg;

   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_WINDOW = 8;

   // Field widths fixed by the interface
   localparam int COORD_W = 6;    // pixel / output coordinates
   localparam int VALUE_W = 16;   // Q8.8 sample
   localparam int PLANE_W = 7;    // plane size registers, also scan counter width
   localparam int PAD_W   = 3;
   localparam int WIN_W   = 4;    // window size and stride registers
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int POS_W   = 12;   // signed window bounds, before and after clipping

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ROWS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_COLS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ROWS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COLS     = 3'd7;

   typedef struct packed {
      logic store;   // write transaction accepted: write the sample
      logic load;    // query transaction accepted: capture the position
      logic mul;     // form position times stride
      logic clip;    // form clipped window bounds
      logic start;   // initialise scan counters and running maximum
      logic scan;    // read one sample at the scan position
      logic emit;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic empty;     // clipped window holds nothing
      logic last;      // scan position is the final sample of the window
      logic out_free;  // result register can take a new result this cycle
   } status_type;

endpackage

// ----- src/mpw_ctrl.sv -----
// Controller state machine for the max pooling window block.
`timescale 1ns / 1ps

module mpw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_stall,
   input  mpw_pkg::status_type status,
   output mpw_pkg::cmd_type    cmd
);
   import mpw_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CLIP  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       idle;

   assign idle      = (state_ff == S_IDLE);
   assign req_stall = !idle;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_type == REQ_QUERY) state_in = S_MUL;
         end
         S_MUL:   state_in = S_CLIP;
         S_CLIP:  state_in = S_CHECK;
         S_CHECK: state_in = status.empty ? S_DONE : S_SCAN;
         S_SCAN: begin
            if (status.last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.store = idle && req_valid && (req_type == REQ_WRITE);
      cmd.load  = idle && req_valid && (req_type == REQ_QUERY);
      cmd.mul   = (state_ff == S_MUL);
      cmd.clip  = (state_ff == S_CLIP);
      cmd.start = (state_ff == S_CHECK) && !status.empty;
      cmd.scan  = (state_ff == S_SCAN);
      cmd.emit  = (state_ff == S_DONE) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a result is never loaded over one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while result register busy");

   // scanning only happens on a window that holds samples
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !status.empty)
      else $error("scan running over an empty window");

   // after a query is taken, no transaction is taken on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("input open straight after a query");
`endif

endmodule

// ----- src/mpw_datapath.sv -----
// Datapath for the max pooling window block: registers, pixel store, bounds and maximum.
`timescale 1ns / 1ps

module mpw_datapath #(
   parameter int MAX_HEIGHT = mpw_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = mpw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = mpw_pkg::DEF_MAX_WINDOW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [mpw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mpw_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [mpw_pkg::COORD_W-1:0]           req_pixel_row,
   input  logic [mpw_pkg::COORD_W-1:0]           req_pixel_col,
   input  logic signed [mpw_pkg::VALUE_W-1:0]    req_pixel_value,
   input  logic [mpw_pkg::COORD_W-1:0]           req_out_row,
   input  logic [mpw_pkg::COORD_W-1:0]           req_out_col,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mpw_pkg::VALUE_W-1:0]    rsp_max_value,
   output logic                                  rsp_window_empty,
   input  mpw_pkg::cmd_type                      cmd,
   output mpw_pkg::status_type                   status
);
   import mpw_pkg::*;

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = COORD_W + WIN_W;

   // configuration registers
   logic [PLANE_W-1:0] plane_height_ff, plane_width_ff;
   logic [PAD_W-1:0]   pad_rows_ff, pad_cols_ff;
   logic [WIN_W-1:0]   window_height_ff, window_width_ff;
   logic [WIN_W-1:0]   step_rows_ff, step_cols_ff;

   // query pipeline
   logic [COORD_W-1:0]      orow_ff, ocol_ff;
   logic [PROD_W-1:0]       prow_ff, pcol_ff;
   logic signed [POS_W-1:0] hs_ff, he_ff, ws_ff, we_ff;
   logic signed [POS_W-1:0] hs_raw, ws_raw, he_raw, we_raw;
   logic signed [POS_W-1:0] ph_s, pw_s;
   logic [PLANE_W-1:0]      ph, pw;
   logic [WIN_W-1:0]        wh, ww;

   // scan
   logic [PLANE_W-1:0]      row_ff, col_ff;
   logic                    col_end, row_end;
   logic                    rd_valid_ff;
   logic [VALUE_W-1:0]      rd_data_ff;
   logic signed [VALUE_W-1:0] best_ff;

   // pixel store
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [AW-1:0]      mem_addr;
   logic [31:0]        waddr_full, raddr_full;
   logic               wr_in_range;

   // result register
   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  rsp_max_value_ff;
   logic                       rsp_window_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff  <= 7'd64;
         plane_width_ff   <= 7'd64;
         pad_rows_ff      <= '0;
         pad_cols_ff      <= '0;
         window_height_ff <= 4'd2;
         window_width_ff  <= 4'd2;
         step_rows_ff     <= 4'd2;
         step_cols_ff     <= 4'd2;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PLANE_HEIGHT:  plane_height_ff  <= csr_wdata;
            CSR_PLANE_WIDTH:   plane_width_ff   <= csr_wdata;
            CSR_PAD_ROWS:      pad_rows_ff      <= csr_wdata[PAD_W-1:0];
            CSR_PAD_COLS:      pad_cols_ff      <= csr_wdata[PAD_W-1:0];
            CSR_WINDOW_HEIGHT: window_height_ff <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_WIDTH:  window_width_ff  <= csr_wdata[WIN_W-1:0];
            CSR_STEP_ROWS:     step_rows_ff     <= csr_wdata[WIN_W-1:0];
            CSR_STEP_COLS:     step_cols_ff     <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate plane and window sizes at the build limits
   assign ph = (32'(plane_height_ff) > MAX_HEIGHT) ? PLANE_W'(MAX_HEIGHT) : plane_height_ff;
   assign pw = (32'(plane_width_ff) > MAX_WIDTH) ? PLANE_W'(MAX_WIDTH) : plane_width_ff;
   assign wh = (32'(window_height_ff) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : window_height_ff;
   assign ww = (32'(window_width_ff) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : window_width_ff;

   assign ph_s = $signed({{(POS_W-PLANE_W){1'b0}}, ph});
   assign pw_s = $signed({{(POS_W-PLANE_W){1'b0}}, pw});

   assign hs_raw = $signed({{(POS_W-PROD_W){1'b0}}, prow_ff})
                 - $signed({{(POS_W-PAD_W){1'b0}}, pad_rows_ff});
   assign ws_raw = $signed({{(POS_W-PROD_W){1'b0}}, pcol_ff})
                 - $signed({{(POS_W-PAD_W){1'b0}}, pad_cols_ff});
   assign he_raw = hs_raw + $signed({{(POS_W-WIN_W){1'b0}}, wh});
   assign we_raw = ws_raw + $signed({{(POS_W-WIN_W){1'b0}}, ww});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         orow_ff <= req_out_row;
         ocol_ff <= req_out_col;
      end
      if (cmd.mul) begin
         prow_ff <= PROD_W'(orow_ff) * PROD_W'(step_rows_ff);
         pcol_ff <= PROD_W'(ocol_ff) * PROD_W'(step_cols_ff);
      end
      if (cmd.clip) begin
         hs_ff <= (hs_raw < 0) ? '0 : hs_raw;
         ws_ff <= (ws_raw < 0) ? '0 : ws_raw;
         he_ff <= (he_raw > ph_s) ? ph_s : he_raw;
         we_ff <= (we_raw > pw_s) ? pw_s : we_raw;
      end
   end

   // once clipped and non-empty, every bound lies within 0..127
   assign col_end = ({1'b0, col_ff} + 8'd1) == we_ff[PLANE_W:0];
   assign row_end = ({1'b0, row_ff} + 8'd1) == he_ff[PLANE_W:0];

   always_comb begin
      status.empty    = (hs_ff >= he_ff) || (ws_ff >= we_ff);
      status.last     = col_end && row_end;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= hs_ff[PLANE_W-1:0];
         col_ff <= ws_ff[PLANE_W-1:0];
      end else if (cmd.scan) begin
         if (col_end) begin
            col_ff <= ws_ff[PLANE_W-1:0];
            row_ff <= row_ff + 7'd1;
         end else begin
            col_ff <= col_ff + 7'd1;
         end
      end
   end

   assign waddr_full  = 32'(req_pixel_row) * 32'(MAX_WIDTH) + 32'(req_pixel_col);
   assign raddr_full  = 32'(row_ff) * 32'(MAX_WIDTH) + 32'(col_ff);
   assign mem_addr    = cmd.scan ? raddr_full[AW-1:0] : waddr_full[AW-1:0];
   assign wr_in_range = (32'(req_pixel_row) < MAX_HEIGHT) && (32'(req_pixel_col) < MAX_WIDTH);

   always_ff @(posedge clock) begin
      if (cmd.store && wr_in_range) begin
         mem[mem_addr] <= req_pixel_value;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan;
      end
   end

   // running maximum, seeded with the most negative sample
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff <= {1'b1, {(VALUE_W-1){1'b0}}};
      end else if (rd_valid_ff && ($signed(rd_data_ff) > best_ff)) begin
         best_ff <= $signed(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_max_value_ff    <= status.empty ? '0 : best_ff;
         rsp_window_empty_ff <= status.empty;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_max_value_ff;
   assign rsp_window_empty = rsp_window_empty_ff;

endmodule

// ----- src/max_pool_window_top.sv -----
// Top level of the max pooling window block.
`timescale 1ns / 1ps

// A write transaction stores one Q8.8 sample in the pixel store and gives no result. A query
// transaction forms position times stride, clips the window, then scans the N samples of the
// clipped window (one store read per cycle on the single port) before loading the result
// register; an empty window skips the scan. The input is held off while a query is being worked
// on; a finished result sits in the output register until taken. The pixel store has no reset
// and must be written before its entries are read by a query.
module max_pool_window_top #(
   parameter int MAX_HEIGHT = mpw_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = mpw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = mpw_pkg::DEF_MAX_WINDOW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mpw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mpw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [mpw_pkg::COORD_W-1:0]        req_pixel_row,
   input  logic [mpw_pkg::COORD_W-1:0]        req_pixel_col,
   input  logic signed [mpw_pkg::VALUE_W-1:0] req_pixel_value,
   input  logic [mpw_pkg::COORD_W-1:0]        req_out_row,
   input  logic [mpw_pkg::COORD_W-1:0]        req_out_col,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mpw_pkg::VALUE_W-1:0] rsp_max_value,
   output logic                               rsp_window_empty
);
   import mpw_pkg::*;

   cmd_type    cmd;
   status_type status;

   mpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mpw_datapath #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_value  (req_pixel_value),
      .req_out_row      (req_out_row),
      .req_out_col      (req_out_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_value    (rsp_max_value),
      .rsp_window_empty (rsp_window_empty),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the max pooling window block: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
   import mpw_pkg::*;

   localparam int STORE_DEPTH   = DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
   localparam int ITEM_TARGET   = 1600;
   localparam int QUIET_FROM    = 1400;
   localparam int SETTLE_CYCLES = 8;
   localparam int FLUSH_CYCLES  = 80;

   typedef struct packed {
      logic                      req_type;
      logic [COORD_W-1:0]        pixel_row;
      logic [COORD_W-1:0]        pixel_col;
      logic signed [VALUE_W-1:0] pixel_value;
      logic [COORD_W-1:0]        out_row;
      logic [COORD_W-1:0]        out_col;
   } pool_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic                      empty;
   } pool_rsp_type;

   typedef struct packed {
      logic [PLANE_W-1:0] plane_height;
      logic [PLANE_W-1:0] plane_width;
      logic [PAD_W-1:0]   pad_rows;
      logic [PAD_W-1:0]   pad_cols;
      logic [WIN_W-1:0]   window_height;
      logic [WIN_W-1:0]   window_width;
      logic [WIN_W-1:0]   step_rows;
      logic [WIN_W-1:0]   step_cols;
   } pool_cfg_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          row_kind;
      logic [CSR_IDX_W-1:0]  csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
      pool_req_type          req;
      bit                    typed;
      pool_rsp_type          rsp;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_type;
   logic [COORD_W-1:0]        req_pixel_row;
   logic [COORD_W-1:0]        req_pixel_col;
   logic signed [VALUE_W-1:0] req_pixel_value;
   logic [COORD_W-1:0]        req_out_row;
   logic [COORD_W-1:0]        req_out_col;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VALUE_W-1:0] rsp_max_value;
   logic                      rsp_window_empty;

   pool_cfg_type              cfg;
   logic signed [VALUE_W-1:0] sample_mem [STORE_DEPTH];
   bit                        sample_known [STORE_DEPTH];
   pool_rsp_type              pending_max[$];
   stim_row_type              directed[$];
   int fails = 0;
   int items_sent = 0;
   int writes_sent = 0;
   int queries_sent = 0;
   int empties_sent = 0;
   int settings_done = 0;
   bit quiet = 1'b0;

   max_pool_window_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_value  (req_pixel_value),
      .req_out_row      (req_out_row),
      .req_out_col      (req_out_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_value    (rsp_max_value),
      .rsp_window_empty (rsp_window_empty)
   );

   always #5 clock = ~clock;

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PLANE_HEIGHT:  cfg.plane_height  = data[PLANE_W-1:0];
         CSR_PLANE_WIDTH:   cfg.plane_width   = data[PLANE_W-1:0];
         CSR_PAD_ROWS:      cfg.pad_rows      = data[PAD_W-1:0];
         CSR_PAD_COLS:      cfg.pad_cols      = data[PAD_W-1:0];
         CSR_WINDOW_HEIGHT: cfg.window_height = data[WIN_W-1:0];
         CSR_WINDOW_WIDTH:  cfg.window_width  = data[WIN_W-1:0];
         CSR_STEP_ROWS:     cfg.step_rows     = data[WIN_W-1:0];
         CSR_STEP_COLS:     cfg.step_cols     = data[WIN_W-1:0];
         default: ;
      endcase
   endfunction

   // Padded window clipped to the plane; sizes saturate at the store and window maxima
   function automatic void clip_window(input logic [COORD_W-1:0] orow,
                                       input logic [COORD_W-1:0] ocol,
                                       output int hs, output int he,
                                       output int ws, output int we);
      int ph, pw, wh, ww;
      ph = (cfg.plane_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(cfg.plane_height);
      pw = (cfg.plane_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cfg.plane_width);
      wh = (cfg.window_height > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(cfg.window_height);
      ww = (cfg.window_width > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(cfg.window_width);
      hs = int'(orow) * int'(cfg.step_rows) - int'(cfg.pad_rows);
      ws = int'(ocol) * int'(cfg.step_cols) - int'(cfg.pad_cols);
      he = hs + wh;
      we = ws + ww;
      if (he > ph) he = ph;
      if (we > pw) we = pw;
      if (hs < 0) hs = 0;
      if (ws < 0) ws = 0;
   endfunction

   function automatic pool_rsp_type pool_max(logic [COORD_W-1:0] orow, logic [COORD_W-1:0] ocol);
      int hs, he, ws, we;
      logic signed [VALUE_W-1:0] best, v;
      pool_rsp_type res;
      clip_window(orow, ocol, hs, he, ws, we);
      if (hs >= he || ws >= we) begin
         res.max_value = '0;
         res.empty = 1'b1;
      end else begin
         best = sample_mem[hs * DEF_MAX_WIDTH + ws];
         for (int h = hs; h < he; h++) begin
            for (int w = ws; w < we; w++) begin
               v = sample_mem[h * DEF_MAX_WIDTH + w];
               if (v > best) best = v;
            end
         end
         res.max_value = best;
         res.empty = 1'b0;
      end
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_sample();
      int k;
      k = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return VALUE_W'((k - 1) * 256);   // few distinct values, so ties happen
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic pool_req_type write_req(int r, int c, logic signed [VALUE_W-1:0] v);
      pool_req_type req;
      req.req_type    = REQ_WRITE;
      req.pixel_row   = COORD_W'(r);
      req.pixel_col   = COORD_W'(c);
      req.pixel_value = v;
      req.out_row     = COORD_W'($urandom);
      req.out_col     = COORD_W'($urandom);
      return req;
   endfunction

   function automatic pool_req_type query_req(int orow, int ocol);
      pool_req_type req;
      req.req_type    = REQ_QUERY;
      req.pixel_row   = COORD_W'($urandom);
      req.pixel_col   = COORD_W'($urandom);
      req.pixel_value = VALUE_W'($urandom);
      req.out_row     = COORD_W'(orow);
      req.out_col     = COORD_W'(ocol);
      return req;
   endfunction

   function automatic stim_row_type item_row(pool_req_type req);
      stim_row_type row;
      row.row_kind  = ROW_ITEM;
      row.csr_index = '0;
      row.csr_data  = '0;
      row.req       = req;
      row.typed     = 1'b0;
      row.rsp       = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(pool_req_type req, logic signed [VALUE_W-1:0] v,
                                              logic empty);
      stim_row_type row;
      row = item_row(req);
      row.typed = 1'b1;
      row.rsp.max_value = v;
      row.rsp.empty = empty;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = item_row('0);
      row.row_kind  = ROW_CSR;
      row.csr_index = idx;
      row.csr_data  = data;
      return row;
   endfunction

   function automatic void build_directed();
      // extremes in the top-left corner under the reset settings
      directed.push_back(item_row(write_req(0, 0, 16'sh7FFF)));
      directed.push_back(item_row(write_req(0, 1, 16'sh8000)));
      directed.push_back(item_row(write_req(1, 0, 16'sh0100)));
      directed.push_back(item_row(write_req(1, 1, -16'sd1)));
      directed.push_back(typed_row(query_req(0, 0), 16'sh7FFF, 1'b0));
      directed.push_back(typed_row(query_req(63, 63), '0, 1'b1));
      // bottom-right corner, all equal to the most negative value
      directed.push_back(item_row(write_req(62, 62, 16'sh8000)));
      directed.push_back(item_row(write_req(62, 63, 16'sh8000)));
      directed.push_back(item_row(write_req(63, 62, 16'sh8000)));
      directed.push_back(item_row(write_req(63, 63, 16'sh8000)));
      directed.push_back(typed_row(query_req(31, 31), 16'sh8000, 1'b0));
      // zero window height
      directed.push_back(csr_row(CSR_WINDOW_HEIGHT, 7'd0));
      directed.push_back(typed_row(query_req(0, 0), '0, 1'b1));
      // oversized window on a 2x2 plane
      directed.push_back(csr_row(CSR_WINDOW_HEIGHT, 7'd15));
      directed.push_back(csr_row(CSR_WINDOW_WIDTH, 7'd9));
      directed.push_back(csr_row(CSR_PLANE_HEIGHT, 7'd2));
      directed.push_back(csr_row(CSR_PLANE_WIDTH, 7'd2));
      directed.push_back(item_row(query_req(0, 0)));
      directed.push_back(typed_row(query_req(1, 1), '0, 1'b1));
      // zero stride with full padding: every window sits at the padded origin
      directed.push_back(csr_row(CSR_STEP_ROWS, 7'd0));
      directed.push_back(csr_row(CSR_STEP_COLS, 7'd0));
      directed.push_back(csr_row(CSR_PAD_ROWS, 7'd7));
      directed.push_back(csr_row(CSR_PAD_COLS, 7'd7));
      directed.push_back(item_row(query_req(63, 63)));
      // oversized height, zero width
      directed.push_back(csr_row(CSR_PLANE_HEIGHT, 7'd127));
      directed.push_back(csr_row(CSR_PLANE_WIDTH, 7'd0));
      directed.push_back(typed_row(query_req(0, 0), '0, 1'b1));
      directed.push_back(csr_row(CSR_PLANE_WIDTH, 7'd127));
      directed.push_back(csr_row(CSR_WINDOW_HEIGHT, 7'd1));
      directed.push_back(csr_row(CSR_WINDOW_WIDTH, 7'd1));
      directed.push_back(csr_row(CSR_PAD_ROWS, 7'd0));
      directed.push_back(csr_row(CSR_PAD_COLS, 7'd0));
      directed.push_back(item_row(query_req(5, 5)));
   endfunction

   function automatic logic [PLANE_W-1:0] rand_plane();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return PLANE_W'(DEF_MAX_HEIGHT);
         2: return PLANE_W'($urandom_range(65, 127));
         default: return PLANE_W'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [WIN_W-1:0] rand_span();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return WIN_W'($urandom_range(9, 15));
         default: return WIN_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic pool_cfg_type random_cfg();
      pool_cfg_type c;
      c.plane_height  = rand_plane();
      c.plane_width   = rand_plane();
      c.pad_rows      = PAD_W'($urandom);
      c.pad_cols      = PAD_W'($urandom);
      c.window_height = rand_span();
      c.window_width  = rand_span();
      c.step_rows     = rand_span();
      c.step_cols     = rand_span();
      return c;
   endfunction

   // output index that mostly lands on or near the plane
   function automatic int pick_out(int plane, int pad, int step);
      int plane_eff, span;
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      plane_eff = (plane > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : plane;
      span = (step == 0) ? 2 : (plane_eff + pad) / step + 1;
      if (span > 63) span = 63;
      return $urandom_range(0, span);
   endfunction

   task automatic send_item(pool_req_type req, bit typed, pool_rsp_type typed_rsp);
      int gap;
      pool_rsp_type exp_rsp;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= req.req_type;
      req_pixel_row   <= req.pixel_row;
      req_pixel_col   <= req.pixel_col;
      req_pixel_value <= req.pixel_value;
      req_out_row     <= req.out_row;
      req_out_col     <= req.out_col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transaction accepted at this edge
      if (req.req_type == REQ_WRITE) begin
         sample_mem[int'(req.pixel_row) * DEF_MAX_WIDTH + int'(req.pixel_col)] = req.pixel_value;
         sample_known[int'(req.pixel_row) * DEF_MAX_WIDTH + int'(req.pixel_col)] = 1'b1;
         writes_sent++;
      end else begin
         exp_rsp = typed ? typed_rsp : pool_max(req.out_row, req.out_col);
         pending_max.push_back(exp_rsp);
         queries_sent++;
         if (exp_rsp.empty) empties_sent++;
      end
      items_sent++;
      quiet = (items_sent >= QUIET_FROM);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_max.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic program_settings(pool_cfg_type next);
      logic [CSR_DATA_W-1:0] vals [8];
      logic [CSR_DATA_W-1:0] noise;
      // narrow registers get junk in the unused upper bits
      noise = CSR_DATA_W'($urandom);
      vals[CSR_PLANE_HEIGHT]  = next.plane_height;
      vals[CSR_PLANE_WIDTH]   = next.plane_width;
      vals[CSR_PAD_ROWS]      = {noise[6:3], next.pad_rows};
      vals[CSR_PAD_COLS]      = {noise[3:0], next.pad_cols};
      vals[CSR_WINDOW_HEIGHT] = {noise[6:4], next.window_height};
      vals[CSR_WINDOW_WIDTH]  = {noise[2:0], next.window_width};
      vals[CSR_STEP_ROWS]     = {noise[5:3], next.step_rows};
      vals[CSR_STEP_COLS]     = {noise[4:2], next.step_cols};
      drain_results();
      for (int i = 0; i < 8; i++) csr_write(CSR_IDX_W'(i), vals[i]);
      csr_write_en <= 1'b0;
      settings_done++;
   endtask

   // writes every sample of the window not yet known, refreshes a few, then queries it
   task automatic pool_sequence(int orow, int ocol);
      int hs, he, ws, we;
      pool_rsp_type none;
      none = '0;
      clip_window(COORD_W'(orow), COORD_W'(ocol), hs, he, ws, we);
      for (int h = hs; h < he; h++) begin
         for (int w = ws; w < we; w++) begin
            if (!sample_known[h * DEF_MAX_WIDTH + w] || $urandom_range(0, 9) == 0)
               send_item(write_req(h, w, rand_sample()), 1'b0, none);
         end
      end
      send_item(query_req(orow, ocol), 1'b0, none);
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(1, 6) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      pool_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_max.size() == 0) begin
            $error("unexpected result: max_value %0d window_empty %0b",
                   rsp_max_value, rsp_window_empty);
            fails++;
         end else begin
            exp_rsp = pending_max.pop_front();
            if (rsp_max_value !== exp_rsp.max_value) begin
               $error("max_value: expected %0d, got %0d", exp_rsp.max_value, rsp_max_value);
               fails++;
            end
            if (rsp_window_empty !== exp_rsp.empty) begin
               $error("window_empty: expected %0b, got %0b", exp_rsp.empty, rsp_window_empty);
               fails++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", pending_max.size());
      $display("max_pool_window_top: mismatch");
      $finish;
   end

   initial begin
      bit prev_csr;
      int phase, phase_end, choice;
      pool_cfg_type next_cfg;
      pool_rsp_type none;
      none            = '0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_type        = REQ_WRITE;
      req_pixel_row   = '0;
      req_pixel_col   = '0;
      req_pixel_value = '0;
      req_out_row     = '0;
      req_out_col     = '0;
      cfg = '{plane_height: 7'd64, plane_width: 7'd64, pad_rows: 3'd0, pad_cols: 3'd0,
              window_height: 4'd2, window_width: 4'd2, step_rows: 4'd2, step_cols: 4'd2};
      build_directed();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].row_kind == ROW_CSR) begin
            if (!prev_csr) drain_results();
            csr_write(directed[i].csr_index, directed[i].csr_data);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) csr_write_en <= 1'b0;
            send_item(directed[i].req, directed[i].typed, directed[i].rsp);
            prev_csr = 1'b0;
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0)
            next_cfg = '{plane_height: 7'd64, plane_width: 7'd64, pad_rows: 3'd7, pad_cols: 3'd7,
                         window_height: 4'd8, window_width: 4'd8, step_rows: 4'd8,
                         step_cols: 4'd8};
         else if (phase == 1)
            next_cfg = '{plane_height: 7'd1, plane_width: 7'd1, pad_rows: 3'd0, pad_cols: 3'd0,
                         window_height: 4'd1, window_width: 4'd1, step_rows: 4'd1,
                         step_cols: 4'd1};
         else
            next_cfg = random_cfg();
         program_settings(next_cfg);
         phase_end = items_sent + $urandom_range(80, 160);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            choice = $urandom_range(0, 19);
            if (choice < 14)
               pool_sequence(pick_out(int'(cfg.plane_height), int'(cfg.pad_rows),
                                      int'(cfg.step_rows)),
                             pick_out(int'(cfg.plane_width), int'(cfg.pad_cols),
                                      int'(cfg.step_cols)));
            else if (choice < 17)
               send_item(write_req($urandom_range(0, 63), $urandom_range(0, 63), rand_sample()),
                         1'b0, none);
            else if (choice == 17)
               drain_results();   // hold off until every pooled result is back
            else
               pool_sequence($urandom_range(0, 63), $urandom_range(0, 63));
         end
         phase++;
      end

      drain_results();
      repeat (FLUSH_CYCLES) @(posedge clock);
      $display("pooled %0d windows (%0d empty) after %0d sample writes, over %0d settings",
               queries_sent, empties_sent, writes_sent, settings_done);
      if (fails == 0)
         $display("max_pool_window_top: match");
      else
         $display("max_pool_window_top: mismatch");
      $finish;
   end

endmodule
